>>> rtl/i2cmrr_pkg.sv
// Shared types and codes for the two-wire register read master.
`default_nettype none

package i2cmrr_pkg;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_READ_REG  = 2'd1,
      CMD_READ_BYTE = 2'd2,
      CMD_STOP      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ADDRW_NACK = 3'd1,
      ST_REG_NACK   = 3'd2,
      ST_ADDRR_NACK = 3'd3,
      ST_BUSY       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      STG_IDLE    = 4'd0,
      STG_START1  = 4'd1,
      STG_ADDRW   = 4'd2,
      STG_ACKW    = 4'd3,
      STG_REG     = 4'd4,
      STG_ACKREG  = 4'd5,
      STG_START2  = 4'd6,
      STG_ADDRR   = 4'd7,
      STG_ACKR    = 4'd8,
      STG_READ    = 4'd9,
      STG_ACKOUT  = 4'd10,
      STG_STOP    = 4'd11,
      STG_STOP_NW = 4'd12,
      STG_STOP_NR = 4'd13
   } stage_type;

   localparam int BYTE_BITS = 8;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic       send_nack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      status_type status;
      logic [7:0] read_data;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/i2cmrr_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface i2cmrr_req_if;
   import i2cmrr_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cmrr_rsp_if;
   import i2cmrr_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/i2cmrr_core.sv
// Bus sequencer state and the per-tick step logic.
`default_nettype none

module i2cmrr_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_en,
   input  wire i2cmrr_pkg::req_item_type item,
   output i2cmrr_pkg::rsp_item_type     result
);
   import i2cmrr_pkg::*;

   stage_type  stage_ff, stage_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [6:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] shift_ff, shift_in;
   logic       nack_ff, nack_in;
   logic       scl_level_ff, scl_level_in;
   logic       sda_level_ff, sda_level_in;

   stage_type  cur_stage;
   logic [1:0] cur_phase;
   logic       rejected;
   logic       done;
   status_type status;
   logic [7:0] rd;
   logic [7:0] send_byte;
   logic [2:0] send_idx;
   logic       send_bit;
   logic [3:0] bit_inc;

   always_comb begin
      cur_stage    = stage_ff;
      cur_phase    = phase_ff;
      bit_count_in = bit_count_ff;
      dev_in       = dev_ff;
      reg_in       = reg_ff;
      shift_in     = shift_ff;
      nack_in      = nack_ff;
      scl_level_in = scl_level_ff;
      sda_level_in = sda_level_ff;
      rejected     = 1'b0;
      done         = 1'b0;
      status       = ST_OK;
      rd           = '0;

      // A command is taken only while idle and starts driving on the same tick.
      if (cur_stage == STG_IDLE) begin
         case (item.cmd)
            CMD_READ_REG: begin
               dev_in       = item.dev_addr;
               reg_in       = item.reg_addr;
               bit_count_in = '0;
               cur_stage    = STG_START1;
               cur_phase    = sda_level_ff ? 2'd1 : 2'd0;
            end
            CMD_READ_BYTE: begin
               nack_in      = item.send_nack;
               shift_in     = '0;
               bit_count_in = '0;
               cur_stage    = STG_READ;
               cur_phase    = 2'd0;
            end
            CMD_STOP: begin
               cur_stage = STG_STOP;
               cur_phase = 2'd0;
            end
            CMD_TICK: ;
         endcase
      end else if (item.cmd != CMD_TICK) begin
         rejected = 1'b1;
      end

      stage_in = cur_stage;
      phase_in = cur_phase;

      case (cur_stage)
         STG_ADDRW: send_byte = {dev_in, 1'b0};
         STG_ADDRR: send_byte = {dev_in, 1'b1};
         STG_REG:   send_byte = reg_in;
         default:   send_byte = {nack_in, 7'b0};
      endcase
      send_idx = 3'd7 - bit_count_in[2:0];
      send_bit = send_byte[send_idx];
      bit_inc  = bit_count_in + 4'd1;

      unique case (cur_stage)
         STG_START1, STG_START2: begin
            if (cur_phase == 2'd0) begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b1;
               phase_in     = 2'd1;
            end else if (cur_phase == 2'd1) begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
               phase_in     = 2'd2;
            end else begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b0;
               bit_count_in = '0;
               stage_in     = (cur_stage == STG_START1) ? STG_ADDRW : STG_ADDRR;
               phase_in     = 2'd0;
            end
         end
         STG_ADDRW, STG_REG, STG_ADDRR, STG_ACKOUT: begin
            if (cur_phase == 2'd0) begin
               scl_level_in = 1'b0;
               sda_level_in = sda_level_ff;
               phase_in     = 2'd1;
            end else if (cur_phase == 2'd1) begin
               scl_level_in = 1'b0;
               sda_level_in = send_bit;
               phase_in     = 2'd2;
            end else begin
               scl_level_in = 1'b1;
               sda_level_in = send_bit;
               bit_count_in = bit_inc;
               phase_in     = 2'd0;
               if (cur_stage == STG_ACKOUT) begin
                  done         = 1'b1;
                  rd           = shift_in;
                  stage_in     = STG_IDLE;
                  bit_count_in = '0;
               end else if (bit_inc >= 4'(BYTE_BITS)) begin
                  bit_count_in = '0;
                  if (cur_stage == STG_ADDRW) begin
                     stage_in = STG_ACKW;
                  end else if (cur_stage == STG_REG) begin
                     stage_in = STG_ACKREG;
                  end else begin
                     stage_in = STG_ACKR;
                  end
               end
            end
         end
         STG_ACKW, STG_ACKREG, STG_ACKR, STG_READ: begin
            if (cur_phase == 2'd0) begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b1;
               phase_in     = 2'd1;
            end else begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
               phase_in     = 2'd0;
               if (cur_stage == STG_READ) begin
                  shift_in     = {shift_in[6:0], item.sda_in};
                  bit_count_in = bit_inc;
                  if (bit_inc >= 4'(BYTE_BITS)) begin
                     bit_count_in = '0;
                     stage_in     = STG_ACKOUT;
                  end
               end else if (cur_stage == STG_ACKW) begin
                  stage_in = item.sda_in ? STG_STOP_NW : STG_REG;
               end else if (cur_stage == STG_ACKREG) begin
                  // A register NACK ends the command at once without a stop.
                  if (item.sda_in) begin
                     done     = 1'b1;
                     status   = ST_REG_NACK;
                     stage_in = STG_IDLE;
                  end else begin
                     stage_in = STG_START2;
                  end
               end else begin
                  if (item.sda_in) begin
                     stage_in = STG_STOP_NR;
                  end else begin
                     done     = 1'b1;
                     stage_in = STG_IDLE;
                  end
               end
            end
         end
         STG_STOP, STG_STOP_NW, STG_STOP_NR: begin
            if (cur_phase == 2'd0) begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b0;
               phase_in     = 2'd1;
            end else if (cur_phase == 2'd1) begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b0;
               phase_in     = 2'd2;
            end else begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
               done         = 1'b1;
               if (cur_stage == STG_STOP_NW) begin
                  status = ST_ADDRW_NACK;
               end else if (cur_stage == STG_STOP_NR) begin
                  status = ST_ADDRR_NACK;
               end else begin
                  status = ST_OK;
               end
               stage_in = STG_IDLE;
               phase_in = 2'd0;
            end
         end
         STG_IDLE: ;
         default: begin
            stage_in = STG_IDLE;
            phase_in = 2'd0;
         end
      endcase

      if (!done && rejected) begin
         status = ST_BUSY;
      end

      result.scl_out   = scl_level_in;
      result.sda_out   = sda_level_in;
      result.busy_res  = (stage_in != STG_IDLE);
      result.done_res  = done;
      result.status    = status;
      result.read_data = rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STG_IDLE;
         phase_ff     <= 2'd0;
         bit_count_ff <= '0;
         dev_ff       <= '0;
         reg_ff       <= '0;
         shift_ff     <= '0;
         nack_ff      <= 1'b0;
         scl_level_ff <= 1'b1;
         sda_level_ff <= 1'b1;
      end else if (step_en) begin
         stage_ff     <= stage_in;
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         dev_ff       <= dev_in;
         reg_ff       <= reg_in;
         shift_ff     <= shift_in;
         nack_ff      <= nack_in;
         scl_level_ff <= scl_level_in;
         sda_level_ff <= sda_level_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/i2c_master_register_read_unit.sv
// A request word is held in the input register, then stepped; its response word is held in the output register.
// Throughput: one word per cycle while the response side takes words; the input register feeds the step logic directly.
// The output register frees the input side while a response waits to be taken.
// Reset (synchronous): both stages empty, sequencer idle, SCL and SDA released high.
`default_nettype none

module i2c_master_register_read_unit (
   input wire logic       clock,
   input wire logic       reset,
   i2cmrr_req_if.sink     req_chan,
   i2cmrr_rsp_if.source   rsp_chan
);
   import i2cmrr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic         out_free;
   logic         step;
   logic         req_fire;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !step);
   assign out_valid_in   = step || (out_valid_ff && !rsp_chan.ready);

   i2cmrr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .item    (in_item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_chan.data;
      end
      if (step) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_item_ff;

endmodule

`default_nettype wire

>>> rtl/i2cmrr_checker.sv
// Port-level checks on the response channel of the register read master.
`default_nettype none

module i2cmrr_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire i2cmrr_pkg::rsp_item_type rsp_data
);
   import i2cmrr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("finished command still reports busy");

   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_BUSY |-> !rsp_data.done_res)
      else $error("busy rejection shown on a finishing tick");

   a_data_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 8'd0 |-> rsp_data.done_res)
      else $error("read data shown outside a done word");

   a_nack_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_ADDRW_NACK || rsp_data.status == ST_ADDRR_NACK)
      |-> rsp_data.scl_out && rsp_data.sda_out)
      else $error("address NACK did not end with the bus released");

endmodule

bind i2c_master_register_read_unit i2cmrr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
